>>> rtl/core/uesc_pkg.sv
// Shared types, verdict codes and literal tables for the URL endpoint check.
package uesc_pkg;

	typedef enum logic [2:0] {
		VERDICT_HTTPS       = 3'd0,
		VERDICT_LOOPBACK    = 3'd1,
		VERDICT_BAD_BYTE    = 3'd2,
		VERDICT_BAD_SCHEME  = 3'd3,
		VERDICT_REMOTE_HTTP = 3'd4
	} verdict_t;

	localparam logic [3:0] HTTP_LEN  = 4'd7;
	localparam logic [3:0] HTTPS_LEN = 4'd8;
	localparam int         NUM_LOOP  = 3;

	// Literal lengths in the order localhost, 127.0.0.1, [::1].
	localparam logic [3:0] LOOP_LEN [NUM_LOOP] = '{4'd9, 4'd9, 4'd5};

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= "A" && c <= "Z") begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic is_forbidden(input logic [7:0] c);
		return (c < 8'h20) || (c == 8'h7f) || (c == "@") || (c == "\\");
	endfunction

	function automatic logic is_authority_end(input logic [7:0] c);
		return (c == "/") || (c == "?") || (c == "#");
	endfunction

	function automatic logic [7:0] http_char(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = "h";
			4'd1: r = "t";
			4'd2: r = "t";
			4'd3: r = "p";
			4'd4: r = ":";
			4'd5: r = "/";
			4'd6: r = "/";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] https_char(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = "h";
			4'd1: r = "t";
			4'd2: r = "t";
			4'd3: r = "p";
			4'd4: r = "s";
			4'd5: r = ":";
			4'd6: r = "/";
			4'd7: r = "/";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] loop_char(input logic [1:0] k, input logic [3:0] idx);
		logic [7:0] r;
		r = 8'h00;
		case (k)
			2'd0: begin
				case (idx)
					4'd0: r = "l";
					4'd1: r = "o";
					4'd2: r = "c";
					4'd3: r = "a";
					4'd4: r = "l";
					4'd5: r = "h";
					4'd6: r = "o";
					4'd7: r = "s";
					4'd8: r = "t";
					default: r = 8'h00;
				endcase
			end
			2'd1: begin
				case (idx)
					4'd0: r = "1";
					4'd1: r = "2";
					4'd2: r = "7";
					4'd3: r = ".";
					4'd4: r = "0";
					4'd5: r = ".";
					4'd6: r = "0";
					4'd7: r = ".";
					4'd8: r = "1";
					default: r = 8'h00;
				endcase
			end
			2'd2: begin
				case (idx)
					4'd0: r = "[";
					4'd1: r = ":";
					4'd2: r = ":";
					4'd3: r = "1";
					4'd4: r = "]";
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/url_endpoint_security_check.sv
// Top level of the URL endpoint security check.
//
// A URL enters on the input channel one byte per word (url_byte), the final
// byte marked by last_byte. Exactly one result word leaves on the output
// channel for each URL: secure, and a verdict code (0 https, 1 loopback http,
// 2 bad byte, 3 bad scheme, 4 http to a non-loopback host).
// A word is registered at the input, parsed by short flag logic, and the
// verdict is registered at the output: a result shows on out_valid once its
// final byte has left the input register and the output register has loaded.
// Throughput is one byte per cycle unless a final byte stalls, set by the
// single parse stage, updating the prefix, host-match and phase flags per byte.
// Bytes that are not final pass through even while a result waits; a final
// byte stalls in the input register only while the output register is still
// full and out_ready is low, and in_ready then falls.
// Reset clears the parse state to the start of a URL and empties both
// registers; after each final byte the parse state returns there as well.
module url_endpoint_security_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] url_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       secure,
	output logic [2:0] verdict
);
	import uesc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_free;
	logic       take;
	verdict_t   verdict_code;

	// Advance a non-final word at once; a final word waits for output room.
	assign take     = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= url_byte;
			last_s1 <= last_byte;
		end
	end

	uesc_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.url_byte     (byte_s1),
		.last_byte    (last_s1),
		.verdict_code (verdict_code)
	);

	uesc_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (take && last_s1),
		.verdict_code (verdict_code),
		.out_ready    (out_ready),
		.free         (out_free),
		.out_valid    (out_valid),
		.secure       (secure),
		.verdict      (verdict)
	);

endmodule

>>> rtl/core/uesc_parser.sv
// Per-word URL parse state and verdict logic.
module uesc_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         url_byte,
	input  logic               last_byte,
	output uesc_pkg::verdict_t verdict_code
);
	import uesc_pkg::*;

	typedef enum logic [2:0] {
		PH_SCHEME        = 3'd0,
		PH_HOST          = 3'd1,
		PH_BRACKET       = 3'd2,
		PH_AFTER_BRACKET = 3'd3,
		PH_PORT          = 3'd4,
		PH_PAST          = 3'd5,
		PH_NOT_HTTP      = 3'd6
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [3:0] pos_q, pos_n;
	logic       bad_q, bad_n;
	logic       http_q, http_n;
	logic       https_q, https_n;
	logic [3:0] hlen_q, hlen_n;
	logic [2:0] match_q, match_n;
	logic       bracket_q, bracket_n;
	logic       malformed_q, malformed_n;
	logic [7:0] lc;
	logic       host_take;
	logic       loopback;
	logic       http_ok;
	logic       https_ok;

	function automatic logic [2:0] match_next(input logic [2:0] m, input logic [3:0] len,
		input logic [7:0] c);
		logic [2:0] r;
		r = m;
		for (int k = 0; k < NUM_LOOP; k++) begin
			if (len >= LOOP_LEN[k] || c != loop_char(2'(k), len)) begin
				r[k] = 1'b0;
			end
		end
		return r;
	endfunction

	always_comb begin
		lc          = lower_ascii(url_byte);
		bad_n       = bad_q | is_forbidden(url_byte);
		http_n      = http_q & ~((pos_q < HTTP_LEN) && (lc != http_char(pos_q)));
		https_n     = https_q & ~((pos_q < HTTPS_LEN) && (lc != https_char(pos_q)));
		phase_n     = phase_q;
		bracket_n   = bracket_q;
		malformed_n = malformed_q;
		host_take   = 1'b0;

		if (phase_q == PH_SCHEME && pos_q == HTTP_LEN) begin
			phase_n = http_n ? PH_HOST : PH_NOT_HTTP;
		end

		case (phase_n)
			PH_HOST: begin
				if (is_authority_end(url_byte)) begin
					phase_n = PH_PAST;
				end else if (url_byte == ":" && !bracket_q) begin
					phase_n = PH_PORT;
				end else begin
					if (hlen_q == 4'd0 && url_byte == "[") begin
						bracket_n = 1'b1;
						phase_n   = PH_BRACKET;
					end
					host_take = 1'b1;
				end
			end
			PH_BRACKET: begin
				if (is_authority_end(url_byte)) begin
					malformed_n = 1'b1;
					phase_n     = PH_PAST;
				end else begin
					host_take = 1'b1;
					if (url_byte == "]") begin
						phase_n = PH_AFTER_BRACKET;
					end
				end
			end
			PH_AFTER_BRACKET: begin
				if (url_byte == ":") begin
					phase_n = PH_PORT;
				end else if (is_authority_end(url_byte)) begin
					phase_n = PH_PAST;
				end else begin
					malformed_n = 1'b1;
					phase_n     = PH_PAST;
				end
			end
			PH_PORT: begin
				if (is_authority_end(url_byte)) begin
					phase_n = PH_PAST;
				end
			end
			default: begin
			end
		endcase

		match_n = host_take ? match_next(match_q, hlen_q, lc) : match_q;
		hlen_n  = (host_take && hlen_q != 4'hf) ? hlen_q + 4'd1 : hlen_q;
		pos_n   = (pos_q != 4'hf) ? pos_q + 4'd1 : pos_q;

		loopback = 1'b0;
		for (int k = 0; k < NUM_LOOP; k++) begin
			if (match_n[k] && hlen_n == LOOP_LEN[k]) begin
				loopback = 1'b1;
			end
		end
		if (malformed_n || phase_n == PH_BRACKET) begin
			loopback = 1'b0;
		end

		http_ok  = http_n && (pos_n >= HTTP_LEN);
		https_ok = https_n && (pos_n >= HTTPS_LEN);

		if (bad_n) begin
			verdict_code = VERDICT_BAD_BYTE;
		end else if (http_ok && loopback) begin
			verdict_code = VERDICT_LOOPBACK;
		end else if (https_ok) begin
			verdict_code = VERDICT_HTTPS;
		end else if (http_ok) begin
			verdict_code = VERDICT_REMOTE_HTTP;
		end else begin
			verdict_code = VERDICT_BAD_SCHEME;
		end
	end

	// Return to the start state after the final word of each URL.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SCHEME;
			pos_q       <= 4'd0;
			bad_q       <= 1'b0;
			http_q      <= 1'b1;
			https_q     <= 1'b1;
			hlen_q      <= 4'd0;
			match_q     <= 3'b111;
			bracket_q   <= 1'b0;
			malformed_q <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				phase_q     <= PH_SCHEME;
				pos_q       <= 4'd0;
				bad_q       <= 1'b0;
				http_q      <= 1'b1;
				https_q     <= 1'b1;
				hlen_q      <= 4'd0;
				match_q     <= 3'b111;
				bracket_q   <= 1'b0;
				malformed_q <= 1'b0;
			end else begin
				phase_q     <= phase_n;
				pos_q       <= pos_n;
				bad_q       <= bad_n;
				http_q      <= http_n;
				https_q     <= https_n;
				hlen_q      <= hlen_n;
				match_q     <= match_n;
				bracket_q   <= bracket_n;
				malformed_q <= malformed_n;
			end
		end
	end

endmodule

>>> rtl/core/uesc_out_reg.sv
// Result register holding one verdict until the receiver takes it.
module uesc_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  uesc_pkg::verdict_t verdict_code,
	input  logic               out_ready,
	output logic               free,
	output logic               out_valid,
	output logic               secure,
	output logic [2:0]         verdict
);
	import uesc_pkg::*;

	logic       valid_q;
	logic       secure_q;
	logic [2:0] verdict_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			secure_q  <= (verdict_code == VERDICT_HTTPS) || (verdict_code == VERDICT_LOOPBACK);
			verdict_q <= verdict_code;
		end
	end

	assign out_valid = valid_q;
	assign secure    = secure_q;
	assign verdict   = verdict_q;

endmodule

>>> rtl/core/uesc_checker.sv
// Port-level checks for the URL endpoint security check, bound to the top level.
module uesc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       secure,
	input logic [2:0] verdict
);
	import uesc_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(secure))
		else $error("result changed while stalled");

	a_secure_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (secure == ((verdict == VERDICT_HTTPS) || (verdict == VERDICT_LOOPBACK))))
		else $error("secure disagrees with verdict");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict <= VERDICT_REMOTE_HTTP))
		else $error("verdict code out of range");

	// With the output register empty, the input side never blocks.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(out_valid) |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind url_endpoint_security_check uesc_checker u_uesc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.secure    (secure),
	.verdict   (verdict)
);
